/* design/rbog_pkg.sv */
// rbog_pkg: shared types, constants and the arctangent table
// for the rotated box overlap block; no dependencies
package rbog_pkg;

  localparam int SizeBits  = 16;
  localparam int CoordBits = 24;
  localparam int AngleBits = 16;
  localparam int FracBits  = 15;
  localparam int Iters     = FracBits + 1;
  localparam int XyBits    = FracBits + 5;
  localparam int ZBits     = 34;
  localparam int IdxBits   = $clog2(Iters);

  // cordic gain 0.60725293500888 rounded to FracBits fraction bits
  localparam logic [XyBits-1:0] CordicInit = XyBits'(19898);
  localparam logic [FracBits:0] TrigOne = (FracBits+1)'(1) << FracBits;

  typedef struct packed {
    logic [SizeBits-1:0]         first_size_x;
    logic [SizeBits-1:0]         first_size_y;
    logic [SizeBits-1:0]         second_size_x;
    logic [SizeBits-1:0]         second_size_y;
    logic [AngleBits-1:0]        first_heading;
    logic [AngleBits-1:0]        second_heading;
    logic signed [CoordBits-1:0] offset_x;
    logic signed [CoordBits-1:0] offset_y;
  } in_t;

  typedef struct packed {
    logic                 overlap;
    logic [CoordBits-1:0] separation_gap;
  } out_t;

  typedef struct packed {
    logic                     valid;
    logic signed [XyBits-1:0] x;
    logic signed [XyBits-1:0] y;
    logic signed [ZBits-1:0]  z;
    logic [1:0]               quad;
    in_t                      args;
  } cordic_t;

  function automatic logic [31:0] arctan(input logic [IdxBits-1:0] i);
    logic [31:0] r;
    unique case (i)
      4'd0:    r = 32'd536870912;
      4'd1:    r = 32'd316933406;
      4'd2:    r = 32'd167458907;
      4'd3:    r = 32'd85004756;
      4'd4:    r = 32'd42667331;
      4'd5:    r = 32'd21354465;
      4'd6:    r = 32'd10679838;
      4'd7:    r = 32'd5340245;
      4'd8:    r = 32'd2670163;
      4'd9:    r = 32'd1335087;
      4'd10:   r = 32'd667544;
      4'd11:   r = 32'd333772;
      4'd12:   r = 32'd166886;
      4'd13:   r = 32'd83443;
      4'd14:   r = 32'd41722;
      default: r = 32'd20861;
    endcase
    return r;
  endfunction

endpackage

/* design/rbog_cordic_cell.sv */
// rbog_cordic_cell: one rotation step of the cordic chain
// depends on rbog_pkg
module rbog_cordic_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rbog_pkg::IdxBits-1:0]   step_i,
  input  rbog_pkg::cordic_t              prev_i,
  output rbog_pkg::cordic_t              next_o
);

  rbog_pkg::cordic_t next_d, data_q;
  logic valid_q;
  logic signed [rbog_pkg::XyBits-1:0] dx, dy;
  logic signed [rbog_pkg::ZBits-1:0]  da;

  always_comb begin
    dx = prev_i.y >>> step_i;
    dy = prev_i.x >>> step_i;
    da = signed'({2'b00, rbog_pkg::arctan(step_i)});
    next_d = prev_i;
    if (prev_i.z >= 0) begin
      next_d.x = prev_i.x - dx;
      next_d.y = prev_i.y + dy;
      next_d.z = prev_i.z - da;
    end else begin
      next_d.x = prev_i.x + dx;
      next_d.y = prev_i.y - dy;
      next_d.z = prev_i.z + da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= next_d;
  end

  // valid comes from the reset register, data fields from the plain one
  always_comb begin
    next_o       = data_q;
    next_o.valid = valid_q;
  end

endmodule

/* design/rbog_gap.sv */
// rbog_gap: trig magnitudes, half extents and per-axis gap stages
// depends on rbog_pkg
module rbog_gap (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbog_pkg::cordic_t cell_i,
  output logic              valid_o,
  output rbog_pkg::out_t    result_o
);

  localparam int F  = rbog_pkg::FracBits;
  localparam int SB = rbog_pkg::SizeBits;
  localparam int CB = rbog_pkg::CoordBits;
  localparam int PB = F + 1 + SB;
  localparam int DB = CB + 3;

  logic [3:0] vld_q;

  // stage 1: magnitudes
  logic [F:0] xm, ym, c_d, s_d, c_q, s_q;
  rbog_pkg::in_t a1_q, a2_q;
  always_comb begin
    xm = cell_i.x < 0 ? (F+1)'(-cell_i.x) : (F+1)'(cell_i.x);
    ym = cell_i.y < 0 ? (F+1)'(-cell_i.y) : (F+1)'(cell_i.y);
    if ((cell_i.x < 0 ? -cell_i.x : cell_i.x) > signed'({4'b0, rbog_pkg::TrigOne}))
      xm = rbog_pkg::TrigOne;
    if ((cell_i.y < 0 ? -cell_i.y : cell_i.y) > signed'({4'b0, rbog_pkg::TrigOne}))
      ym = rbog_pkg::TrigOne;
    c_d = cell_i.quad[0] ? ym : xm;
    s_d = cell_i.quad[0] ? xm : ym;
  end

  // stage 2: products
  logic [PB-1:0] cx_q, sy_q, sx_q, cy_q;

  // stage 3: axis distances
  logic [PB:0] hx, hy;
  logic [CB:0] mx, my;
  logic signed [DB-1:0] dx_d, dy_d, dx_q, dy_q;
  always_comb begin
    hx = {1'b0, cx_q} + {1'b0, sy_q};
    hy = {1'b0, sx_q} + {1'b0, cy_q};
    mx = a2_q.offset_x < 0 ? (CB+1)'(-{a2_q.offset_x[CB-1], a2_q.offset_x})
                          : (CB+1)'(a2_q.offset_x);
    my = a2_q.offset_y < 0 ? (CB+1)'(-{a2_q.offset_y[CB-1], a2_q.offset_y})
                          : (CB+1)'(a2_q.offset_y);
    dx_d = signed'({1'b0, mx, 1'b0}) - signed'(DB'(a2_q.first_size_x))
         - signed'(DB'(hx >> F));
    dy_d = signed'({1'b0, my, 1'b0}) - signed'(DB'(a2_q.first_size_y))
         - signed'(DB'(hy >> F));
  end

  // stage 4: gaps, max, saturation
  logic [DB-1:0] gx, gy, best;
  rbog_pkg::out_t res_d, res_q;
  always_comb begin
    gx = dx_q > 0 ? DB'((dx_q + 1) >>> 1) : '0;
    gy = dy_q > 0 ? DB'((dy_q + 1) >>> 1) : '0;
    best = gx > gy ? gx : gy;
    res_d.overlap = (gx == '0) && (gy == '0);
    res_d.separation_gap = (best >> CB) != '0 ? {CB{1'b1}} : best[CB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], cell_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    c_q  <= c_d;
    s_q  <= s_d;
    a1_q <= cell_i.args;
    cx_q <= PB'(c_q) * PB'(a1_q.second_size_x);
    sy_q <= PB'(s_q) * PB'(a1_q.second_size_y);
    sx_q <= PB'(s_q) * PB'(a1_q.second_size_x);
    cy_q <= PB'(c_q) * PB'(a1_q.second_size_y);
    a2_q <= a1_q;
    dx_q <= dx_d;
    dy_q <= dy_d;
    res_q <= res_d;
  end

  assign valid_o  = vld_q[3];
  assign result_o = res_q;

endmodule

/* design/rotated_box_overlap_gap.sv */
// rotated_box_overlap_gap: top level, cordic cell chain and gap stages
// depends on rbog_pkg, rbog_cordic_cell, rbog_gap
//
// Overlap test of a reference box and a rotated, offset second box.
// Input channel: an item (in_i) is taken at a clock edge with start_i high
// and busy_o low. busy_o is always low: the block is fully pipelined and
// takes one item every cycle.
// Result channel: result_o is valid for exactly one cycle while
// result_valid_o is high; the receiver cannot stall it.
// Path: an accepted item passes the chain of 16 cordic cells (one rotation
// step each), then the magnitude, multiply, distance and gap stages.
// Throughput: one item per cycle, results in input order.
// Reset (rst_ni low, asynchronous) clears all valid flags; items in
// flight are dropped and no strobe is given until new items arrive.
module rotated_box_overlap_gap (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  rbog_pkg::in_t  in_i,
  output logic           result_valid_o,
  output rbog_pkg::out_t result_o
);

  localparam int N = rbog_pkg::Iters;

  rbog_pkg::cordic_t chain [N+1];
  logic [rbog_pkg::AngleBits-1:0] diff;

  assign busy_o = 1'b0;

  always_comb begin
    diff = in_i.second_heading - in_i.first_heading;
    chain[0].valid = start_i;
    chain[0].x     = rbog_pkg::CordicInit;
    chain[0].y     = '0;
    chain[0].quad  = diff[rbog_pkg::AngleBits-1 -: 2];
    chain[0].z     = signed'(rbog_pkg::ZBits'(
                       {diff[rbog_pkg::AngleBits-3:0], {(32-rbog_pkg::AngleBits){1'b0}}}));
    chain[0].args  = in_i;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    rbog_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (rbog_pkg::IdxBits'(g)),
      .prev_i (chain[g]),
      .next_o (chain[g+1])
    );
  end

  rbog_gap u_gap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cell_i   (chain[N]),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

/* tb/rbog_checker.sv */
// rbog_checker: predicts overlap and gap for each accepted item and compares
// the result strobes against them; depends on rbog_pkg
`timescale 1ns / 100ps
module rbog_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_o,
  input  rbog_pkg::in_t  in_i,
  input  logic           result_valid_o,
  input  rbog_pkg::out_t result_o,
  output int             fail_count_o,
  output int             pending_o
);

  rbog_pkg::out_t expected_q[$];
  int   fail_count = 0;

  localparam longint ArcTab[16] = '{536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  assign fail_count_o = fail_count;
  assign pending_o    = expected_q.size();

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint axis_gap(longint offset, longint first_size, longint half_ext);
    longint mag, d;
    mag = offset < 0 ? -offset : offset;
    d = 2 * mag - first_size - (half_ext >>> rbog_pkg::FracBits);
    if (d <= 0) return 0;
    return (d + 1) >>> 1;
  endfunction

  function automatic rbog_pkg::out_t predict_overlap(rbog_pkg::in_t it);
    logic [rbog_pkg::AngleBits-1:0] diff;
    logic [31:0] a;
    longint x, y, z, dx, dy, c, s, hx, hy, gx, gy, best, one;
    rbog_pkg::out_t r;
    diff = it.second_heading - it.first_heading;
    a = {diff, 16'd0};
    z = longint'(a[29:0]);
    one = 1 << rbog_pkg::FracBits;
    x = (64'd2608131497 + (64'd1 << (31 - rbog_pkg::FracBits))) >> (32 - rbog_pkg::FracBits);
    y = 0;
    for (int i = 0; i < rbog_pkg::Iters; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ArcTab[i];
      end else begin
        x += dx; y -= dy; z += ArcTab[i];
      end
    end
    if (x < 0) x = -x;
    if (y < 0) y = -y;
    if (x > one) x = one;
    if (y > one) y = one;
    if (a[30]) begin
      c = y; s = x;
    end else begin
      c = x; s = y;
    end
    hx = c * it.second_size_x + s * it.second_size_y;
    hy = s * it.second_size_x + c * it.second_size_y;
    gx = axis_gap(longint'(it.offset_x), it.first_size_x, hx);
    gy = axis_gap(longint'(it.offset_y), it.first_size_y, hy);
    best = gx > gy ? gx : gy;
    if (best > (1 << rbog_pkg::CoordBits) - 1) best = (1 << rbog_pkg::CoordBits) - 1;
    r.overlap = (gx == 0 && gy == 0);
    r.separation_gap = best[rbog_pkg::CoordBits-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    rbog_pkg::out_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) expected_q.insert(expected_q.size(), predict_overlap(in_i));
      if (result_valid_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result overlap=%0d gap=%0d", $time,
                   result_o.overlap, result_o.separation_gap);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (want.overlap !== result_o.overlap) begin
            $display("%0t: overlap expected %0d actual %0d", $time,
                     want.overlap, result_o.overlap);
            fail_count++;
          end
          if (want.separation_gap !== result_o.separation_gap) begin
            $display("%0t: gap expected %0d actual %0d", $time,
                     want.separation_gap, result_o.separation_gap);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

/* tb/tb_top.sv */
// tb_top: stimulus and verdict for rotated_box_overlap_gap
// depends on rbog_pkg, rotated_box_overlap_gap and rbog_checker
`timescale 1ns / 100ps
module tb_top;

  localparam int WatchdogLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  rbog_pkg::in_t  in_i = '0;
  logic busy_o, result_valid_o;
  rbog_pkg::out_t result_o;
  int   fail_count, pending;
  int   idle_cycles = 0;
  int   box_count = 0;

  always #1 clk_i = ~clk_i;

  rotated_box_overlap_gap DUT (.*);
  rbog_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // start stays high across back-to-back items and drops only for a gap
  task automatic send_box(rbog_pkg::in_t it, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= it;
    do @(posedge clk_i); while (busy_o);
    box_count++;
  endtask

  function automatic rbog_pkg::in_t random_box(int mode);
    rbog_pkg::in_t it;
    it.first_size_x   = 16'($urandom);
    it.first_size_y   = 16'($urandom);
    it.second_size_x  = 16'($urandom);
    it.second_size_y  = 16'($urandom);
    it.first_heading  = 16'($urandom);
    it.second_heading = 16'($urandom);
    it.offset_x       = 24'($urandom);
    it.offset_y       = 24'($urandom);
    if (mode < 6) begin
      // offsets near the contact distance so overlap and gap both appear
      it.first_size_x  = 16'($urandom_range(0, 4000));
      it.first_size_y  = 16'($urandom_range(0, 4000));
      it.second_size_x = 16'($urandom_range(0, 4000));
      it.second_size_y = 16'($urandom_range(0, 4000));
      it.offset_x = 24'($urandom_range(0, 8000));
      if ($urandom_range(0, 1) != 0) it.offset_x = -it.offset_x;
      it.offset_y = 24'($urandom_range(0, 8000));
      if ($urandom_range(0, 1) != 0) it.offset_y = -it.offset_y;
    end
    return it;
  endfunction

  initial begin
    rbog_pkg::in_t it;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // extremes, touching boxes, degenerate boxes, each quadrant
    send_box('0, 0);
    send_box('1, 0);
    it = '0; it.first_size_x = 16'hffff; it.first_size_y = 16'hffff;
    it.second_size_x = 16'hffff; it.second_size_y = 16'hffff;
    it.offset_x = 24'sh800000; it.offset_y = 24'sh7fffff;
    send_box(it, 0);
    it = '0; it.offset_x = 24'sh800000; it.offset_y = 24'sh800000;
    send_box(it, 1);
    it = '0; it.first_size_x = 16'd100; it.second_size_x = 16'd100;
    it.offset_x = 24'sd100;
    send_box(it, 0);
    it.offset_x = 24'sd101;
    send_box(it, 0);
    it.offset_x = -24'sd101;
    send_box(it, 0);
    for (int q = 0; q < 8; q++) begin
      it = '0;
      it.first_size_x = 16'd1000; it.first_size_y = 16'd500;
      it.second_size_x = 16'd2000; it.second_size_y = 16'd300;
      it.first_heading = 16'h1234;
      it.second_heading = 16'h1234 + 16'(q * 16'h2000);
      it.offset_x = 24'sd1200; it.offset_y = -24'sd700;
      send_box(it, 0);
    end
    it.second_heading = 16'h0000; it.first_heading = 16'hffff;
    send_box(it, 0);
    // hold off until the pipeline drains
    start_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
    for (int n = 0; n < 1050; n++) begin
      if (n % 200 < 40) send_box(random_box($urandom_range(0, 9)), 0);
      else send_box(random_box($urandom_range(0, 9)), $urandom_range(0, 16));
    end
    start_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (25) @(posedge clk_i);
    $display("sent %0d box pairs: extremes, touching, all quadrants, random", box_count);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
